// ----- hdl/bnms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Box NMS package
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int Q_W       = 17;
  localparam int CLS_W     = 8;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W   = Q_W + 1;
  localparam int MUL_B_W   = 2 * Q_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [Q_W-1:0] THR_RESET = Q_W'(32768);

  typedef struct packed {
    logic [Q_W-1:0]   box_left;
    logic [Q_W-1:0]   box_top;
    logic [Q_W-1:0]   box_width;
    logic [Q_W-1:0]   box_height;
    logic [Q_W-1:0]   box_score;
    logic [CLS_W-1:0] box_class;
    logic             set_end;
  } in_t;

  typedef struct packed {
    logic [Q_W-1:0]   kept_left;
    logic [Q_W-1:0]   kept_top;
    logic [Q_W-1:0]   kept_width;
    logic [Q_W-1:0]   kept_height;
    logic [Q_W-1:0]   kept_score;
    logic [CLS_W-1:0] kept_class;
    logic             kept_last;
    logic             set_overflow;
  } out_t;

  // One stored box
  typedef struct packed {
    logic [Q_W-1:0]   left;
    logic [Q_W-1:0]   top;
    logic [Q_W-1:0]   width;
    logic [Q_W-1:0]   height;
    logic [Q_W-1:0]   score;
    logic [CLS_W-1:0] cls;
  } box_t;

  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] thr;
  } iou_req_t;

  typedef struct packed {
    logic done;
    logic suppress;
  } iou_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/bnms_iou_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Box NMS overlap unit
// Decides whether one kept box suppresses a candidate, using one shared
// multiplier in steps: overlap, two areas, union (an add) and threshold product.
// ----------------------------------------------------------------------------
module bnms_iou_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bnms_pkg::iou_req_t req,
  input  wire bnms_pkg::box_t   box_a,
  input  wire bnms_pkg::box_t   box_b,
  output bnms_pkg::iou_rsp_t    rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INT  = 3'd1;
  localparam logic [2:0] S_AA   = 3'd2;
  localparam logic [2:0] S_BB   = 3'd3;
  localparam logic [2:0] S_UNI  = 3'd4;
  localparam logic [2:0] S_THR  = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;

  localparam int QW = bnms_pkg::Q_W;
  localparam int AW = bnms_pkg::MUL_A_W;
  localparam int BW = bnms_pkg::MUL_B_W;
  localparam int PW = bnms_pkg::PROD_W;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] ow_r, oh_r;
  logic [QW-1:0] aw_r, ah_r, bw_r, bh_r, thr_r;
  logic [PW-1:0] prod_r;
  logic [BW-1:0] inter_r, area_r, uni_r;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;

  // Overlap extent of the two boxes
  logic [QW-1:0] x1, y1;
  logic [AW-1:0] ax2, bx2, ay2, by2, x2, y2, ow, oh;
  logic [BW:0]   uni_sum;

  always_comb begin
    x1  = (box_a.left > box_b.left) ? box_a.left : box_b.left;
    y1  = (box_a.top > box_b.top) ? box_a.top : box_b.top;
    ax2 = AW'(box_a.left) + AW'(box_a.width);
    bx2 = AW'(box_b.left) + AW'(box_b.width);
    ay2 = AW'(box_a.top) + AW'(box_a.height);
    by2 = AW'(box_b.top) + AW'(box_b.height);
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    ow  = (x2 > AW'(x1)) ? x2 - AW'(x1) : '0;
    oh  = (y2 > AW'(y1)) ? y2 - AW'(y1) : '0;
    uni_sum = (BW+1)'(area_r) + (BW+1)'(prod_r[BW-1:0]) - (BW+1)'(inter_r);
  end

  // Operand selection for the shared multiplier
  always_comb begin
    unique case (state_r)
      S_INT:   begin mul_a = ow_r;          mul_b = BW'(oh_r); end
      S_AA:    begin mul_a = AW'(aw_r);     mul_b = BW'(ah_r); end
      S_BB:    begin mul_a = AW'(bw_r);     mul_b = BW'(bh_r); end
      S_THR:   begin mul_a = AW'(thr_r);    mul_b = uni_r;     end
      default: begin mul_a = '0;            mul_b = '0;        end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (req.start) state_nxt = S_INT;
      S_INT:   state_nxt = S_AA;
      S_AA:    state_nxt = S_BB;
      S_BB:    state_nxt = S_UNI;
      S_UNI:   state_nxt = S_THR;
      S_THR:   state_nxt = S_CMP;
      S_CMP:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
    if (state_r == S_IDLE && req.start) begin
      ow_r  <= ow;
      oh_r  <= oh;
      aw_r  <= box_a.width;
      ah_r  <= box_a.height;
      bw_r  <= box_b.width;
      bh_r  <= box_b.height;
      thr_r <= req.thr;
    end
    if (state_r == S_AA) begin
      inter_r <= prod_r[BW-1:0];
    end
    if (state_r == S_BB) begin
      area_r <= prod_r[BW-1:0];
    end
    if (state_r == S_UNI) begin
      uni_r <= uni_sum[BW-1:0];
    end
  end

  // Decision: overlap * 2^16 >= threshold * union; a zero union suppresses only at threshold zero
  always_comb begin
    rsp.done = (state_r == S_CMP);
    if (uni_r == '0) begin
      rsp.suppress = (thr_r == '0);
    end else begin
      rsp.suppress = ((PW'(inter_r) << 16) >= prod_r);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/box_non_max_suppression_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Box non-maximum suppression
// Loads a set of boxes into a score-ranked store, then walks the ranking and
// emits each box that no earlier kept box overlaps at or past the threshold.
// ----------------------------------------------------------------------------
// Load: the insertion walk reads and then writes each store entry that it moves.
// Close: each candidate is tested against earlier kept boxes, then kept boxes are emitted.
// One box at a time: a new box is taken only while the block is idle.
// Reset (rst_n low, synchronous) empties the set and sets threshold to 32768.
// Store contents are not cleared by reset; only filled entries are ever read.
module box_non_max_suppression_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire bnms_pkg::in_t             in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output bnms_pkg::out_t                 out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [bnms_pkg::Q_W-1:0]  cfg_data
);

  localparam int IW = bnms_pkg::IDX_W;
  localparam int CW = bnms_pkg::CNT_W;
  localparam logic [CW-1:0] MAXC = CW'(bnms_pkg::MAX_BOXES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INS   = 4'd1;
  localparam logic [3:0] S_INSC  = 4'd2;
  localparam logic [3:0] S_CRD   = 4'd3;
  localparam logic [3:0] S_CLAT  = 4'd4;
  localparam logic [3:0] S_KRD   = 4'd5;
  localparam logic [3:0] S_KGO   = 4'd6;
  localparam logic [3:0] S_KIOU  = 4'd7;
  localparam logic [3:0] S_ERD   = 4'd8;
  localparam logic [3:0] S_ELD   = 4'd9;
  localparam logic [3:0] S_EOUT  = 4'd10;

  logic [3:0]    state_r;
  logic [CW-1:0] count_r, pos_r, rank_r, k_r, emit_r, last_r;
  logic          ovf_r, end_r;
  logic [bnms_pkg::Q_W-1:0] thr_r;
  logic [bnms_pkg::MAX_BOXES-1:0] kept_r;
  bnms_pkg::box_t new_r, cand_r, rd_data_r;

  // Ranked box store
  bnms_pkg::box_t store_r [bnms_pkg::MAX_BOXES];
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  bnms_pkg::box_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  // Overlap unit
  bnms_pkg::iou_req_t iou_req;
  bnms_pkg::iou_rsp_t iou_rsp;

  bnms_iou_unit u_iou (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iou_req),
    .box_a (rd_data_r),
    .box_b (cand_r),
    .rsp   (iou_rsp)
  );

  logic [CW-1:0] pos_m1;
  assign pos_m1 = pos_r - CW'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Store port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r[IW-1:0];
    wr_data = new_r;
    rd_en   = 1'b0;
    rd_addr = pos_m1[IW-1:0];
    iou_req.start = (state_r == S_KGO);
    iou_req.thr   = thr_r;
    unique case (state_r)
      S_INS: begin
        if (pos_r == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_INSC: begin
        wr_en = 1'b1;
        if (rd_data_r.score < new_r.score) begin
          wr_data = rd_data_r;
        end
      end
      S_CRD: begin
        rd_en   = 1'b1;
        rd_addr = rank_r[IW-1:0];
      end
      S_KRD: begin
        rd_en   = (k_r != rank_r) && kept_r[k_r[IW-1:0]];
        rd_addr = k_r[IW-1:0];
      end
      S_ERD: begin
        rd_en   = (emit_r != count_r) && kept_r[emit_r[IW-1:0]];
        rd_addr = emit_r[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      kept_r    <= '0;
      thr_r     <= bnms_pkg::THR_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            new_r <= '{in_data.box_left, in_data.box_top, in_data.box_width,
                       in_data.box_height, in_data.box_score, in_data.box_class};
            end_r  <= in_data.set_end;
            pos_r  <= count_r;
            rank_r <= '0;
            k_r    <= '0;
            if (count_r == MAXC) begin
              ovf_r   <= 1'b1;
              state_r <= in_data.set_end ? S_CRD : S_IDLE;
            end else begin
              state_r <= S_INS;
            end
          end
        end
        S_INS: begin
          if (pos_r == '0) begin
            count_r <= count_r + CW'(1);
            state_r <= end_r ? S_CRD : S_IDLE;
          end else begin
            state_r <= S_INSC;
          end
        end
        S_INSC: begin
          // Equal scores stay ahead of the new box
          if (rd_data_r.score < new_r.score) begin
            pos_r   <= pos_m1;
            state_r <= S_INS;
          end else begin
            count_r <= count_r + CW'(1);
            state_r <= end_r ? S_CRD : S_IDLE;
          end
        end
        S_CRD: begin
          k_r     <= '0;
          state_r <= S_CLAT;
        end
        S_CLAT: begin
          cand_r  <= rd_data_r;
          state_r <= S_KRD;
        end
        S_KRD: begin
          if (k_r == rank_r) begin
            // No kept box suppresses the candidate
            kept_r[rank_r[IW-1:0]] <= 1'b1;
            last_r <= rank_r;
            rank_r <= rank_r + CW'(1);
            emit_r <= '0;
            state_r <= (rank_r + CW'(1) == count_r) ? S_ERD : S_CRD;
          end else if (!kept_r[k_r[IW-1:0]]) begin
            k_r <= k_r + CW'(1);
          end else begin
            state_r <= S_KGO;
          end
        end
        S_KGO: begin
          state_r <= S_KIOU;
        end
        S_KIOU: begin
          if (iou_rsp.done) begin
            if (iou_rsp.suppress) begin
              rank_r  <= rank_r + CW'(1);
              emit_r  <= '0;
              state_r <= (rank_r + CW'(1) == count_r) ? S_ERD : S_CRD;
            end else begin
              k_r     <= k_r + CW'(1);
              state_r <= S_KRD;
            end
          end
        end
        S_ERD: begin
          if (emit_r == count_r) begin
            count_r <= '0;
            ovf_r   <= 1'b0;
            kept_r  <= '0;
            state_r <= S_IDLE;
          end else if (!kept_r[emit_r[IW-1:0]]) begin
            emit_r <= emit_r + CW'(1);
          end else begin
            state_r <= S_ELD;
          end
        end
        S_ELD: begin
          out_data <= '{rd_data_r.left, rd_data_r.top, rd_data_r.width,
                        rd_data_r.height, rd_data_r.score, rd_data_r.cls,
                        (emit_r == last_r), ovf_r};
          out_valid <= 1'b1;
          state_r   <= S_EOUT;
        end
        S_EOUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            emit_r    <= emit_r + CW'(1);
            state_r   <= S_ERD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXC) else $error("box count beyond store depth");

  a_emit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> kept_r[emit_r[IW-1:0]]) else $error("emitting a box not kept");

  a_iou_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    iou_rsp.done |-> (state_r == S_KIOU)) else $error("overlap result unexpected");

endmodule
`default_nettype wire

// ----- tb/sv/tb_box_non_max_suppression_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box non-maximum suppression testbench
// Sends sets of boxes through the block, predicts the kept boxes with its own
// greedy ranking and overlap test, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_box_non_max_suppression_top;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  bnms_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  bnms_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [bnms_pkg::Q_W-1:0] cfg_data;

  // Predictor state
  bnms_pkg::box_t held_boxes[$];
  bit overflow_flag;
  logic [bnms_pkg::Q_W-1:0] threshold;
  bnms_pkg::out_t kept_queue[$];
  int fail_count;
  bit idle_off;

  box_non_max_suppression_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // True when box a suppresses box b at the current threshold.
  function automatic bit suppresses(bnms_pkg::box_t a, bnms_pkg::box_t b);
    logic [63:0] x1, y1, x2, y2, ow, oh, inter, uni;
    x1 = (a.left > b.left) ? a.left : b.left;
    y1 = (a.top > b.top) ? a.top : b.top;
    x2 = ((64'(a.left) + a.width) < (64'(b.left) + b.width)) ?
         64'(a.left) + a.width : 64'(b.left) + b.width;
    y2 = ((64'(a.top) + a.height) < (64'(b.top) + b.height)) ?
         64'(a.top) + a.height : 64'(b.top) + b.height;
    ow = (x2 > x1) ? x2 - x1 : 0;
    oh = (y2 > y1) ? y2 - y1 : 0;
    inter = ow * oh;
    uni = 64'(a.width) * a.height + 64'(b.width) * b.height - inter;
    if (uni == 0) return threshold == 0;
    return (inter << 16) >= 64'(threshold) * uni;
  endfunction

  // Ranks the held set, applies greedy suppression and queues the kept boxes.
  task automatic predict_kept_boxes();
    bnms_pkg::box_t ranked[$];
    bnms_pkg::box_t kept[$];
    int pos;
    bit dup;
    bnms_pkg::out_t res;
    foreach (held_boxes[i]) begin
      pos = ranked.size();
      // Stable insertion: equal scores stay behind earlier boxes.
      for (int r = 0; r < ranked.size(); r++)
        if (held_boxes[i].score > ranked[r].score) begin
          pos = r;
          break;
        end
      ranked.insert(pos, held_boxes[i]);
    end
    foreach (ranked[r]) begin
      dup = 1'b0;
      foreach (kept[k]) if (suppresses(kept[k], ranked[r])) dup = 1'b1;
      if (!dup) kept = {kept, ranked[r]};
    end
    foreach (kept[k]) begin
      res.kept_left = kept[k].left;
      res.kept_top = kept[k].top;
      res.kept_width = kept[k].width;
      res.kept_height = kept[k].height;
      res.kept_score = kept[k].score;
      res.kept_class = kept[k].cls;
      res.kept_last = (k == kept.size() - 1);
      res.set_overflow = overflow_flag;
      kept_queue = {kept_queue, res};
    end
    held_boxes.delete();
    overflow_flag = 1'b0;
  endtask

  function automatic bit idle_now();
    return !idle_off && ($urandom_range(99) < 8);
  endfunction

  // Sends one box beat and updates the prediction on acceptance.
  task automatic send_box(bnms_pkg::in_t b);
    bnms_pkg::box_t s;
    while (idle_now()) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    s.left = b.box_left; s.top = b.box_top; s.width = b.box_width;
    s.height = b.box_height; s.score = b.box_score; s.cls = b.box_class;
    if (held_boxes.size() < bnms_pkg::MAX_BOXES) held_boxes = {held_boxes, s};
    else overflow_flag = 1'b1;
    if (b.set_end) predict_kept_boxes();
    // The block leaves idle after a beat unless the beat is dropped on overflow.
    @(posedge clk);
  endtask

  function automatic bnms_pkg::in_t make_box(int l, int t, int w, int h, int sc,
                                             int c, bit e);
    bnms_pkg::in_t b;
    b.box_left = l[bnms_pkg::Q_W-1:0];
    b.box_top = t[bnms_pkg::Q_W-1:0];
    b.box_width = w[bnms_pkg::Q_W-1:0];
    b.box_height = h[bnms_pkg::Q_W-1:0];
    b.box_score = sc[bnms_pkg::Q_W-1:0];
    b.box_class = c[bnms_pkg::CLS_W-1:0];
    b.set_end = e;
    return b;
  endfunction

  function automatic bnms_pkg::in_t random_box(bit e);
    int pick;
    pick = $urandom_range(9);
    // Mostly clustered boxes so that overlaps decide the outcome.
    if (pick < 7)
      return make_box($urandom_range(20000, 26000), $urandom_range(20000, 26000),
                      $urandom_range(1, 12000), $urandom_range(1, 12000),
                      $urandom_range(65536), $urandom_range(255), e);
    else if (pick < 8)
      return make_box($urandom_range(65536), $urandom_range(65536),
                      $urandom_range(65536), $urandom_range(65536),
                      $urandom_range(3) * 21845, $urandom_range(255), e);
    return make_box($urandom_range(65536), $urandom_range(65536),
                    $urandom_range(65536), $urandom_range(65536),
                    $urandom_range(65536), $urandom_range(255), e);
  endfunction

  // Waits until all kept boxes have arrived and the block has settled.
  task automatic wait_drained();
    while (kept_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_threshold(int v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v[bnms_pkg::Q_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    threshold = v[bnms_pkg::Q_W-1:0];
  endtask

  task automatic test_extremes();
    send_box(make_box(0, 0, 0, 0, 0, 0, 1'b0));
    send_box(make_box(65536, 65536, 65536, 65536, 65536, 255, 1'b0));
    send_box(make_box(0, 0, 65536, 65536, 65536, 170, 1'b0));
    send_box(make_box(65535, 1, 1, 65535, 1, 85, 1'b1));
    send_box(make_box(100, 100, 1000, 1000, 500, 1, 1'b1));
  endtask

  // Equal scores keep load order; identical boxes suppress each other.
  task automatic test_ties_and_overlap();
    send_box(make_box(1000, 1000, 4000, 4000, 30000, 2, 1'b0));
    send_box(make_box(1000, 1000, 4000, 4000, 30000, 3, 1'b0));
    send_box(make_box(2000, 1000, 4000, 4000, 40000, 4, 1'b0));
    send_box(make_box(50000, 50000, 0, 0, 30000, 5, 1'b0));
    send_box(make_box(50000, 50000, 0, 0, 20000, 6, 1'b1));
  endtask

  task automatic test_thresholds();
    int limits[4] = '{0, 1, 65536, 131071};
    foreach (limits[i]) begin
      write_threshold(limits[i]);
      for (int k = 0; k < 3; k++) send_box(random_box(k == 2));
    end
    write_threshold(32768);
  endtask

  // A full store drops the extra boxes, the last of which still closes the set.
  task automatic test_overflow();
    for (int k = 0; k < bnms_pkg::MAX_BOXES + 2; k++)
      send_box(random_box(k == bnms_pkg::MAX_BOXES + 1));
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    sent = 0;
    while (sent < 110) begin
      if (sent > 30 && sent < 80) idle_off = 1'b1;
      else idle_off = 1'b0;
      if (sent % 50 == 0) write_threshold($urandom_range(1, 65536));
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) send_box(random_box(k == len - 1));
      sent += len;
    end
    idle_off = 1'b0;
  endtask

  // Receiver: random stalls and comparison against the oldest kept box.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_now();
      if (out_valid && out_ready) begin
        if (kept_queue.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
          fail_count++;
        end else begin
          if (out_data !== kept_queue[0]) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, kept_queue[0],
                     out_data);
            fail_count++;
          end
          void'(kept_queue.pop_front());
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    threshold = bnms_pkg::THR_RESET;
    overflow_flag = 1'b0;
    fail_count = 0;
    idle_off = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_ties_and_overlap();
    test_thresholds();
    test_overflow();
    test_random_sets();
    wait_drained();
    if (fail_count == 0) $display("tb_box_non_max_suppression_top: PASS");
    else $display("tb_box_non_max_suppression_top: FAIL");
    $finish;
  end

  // Generous bound on the whole run.
  initial begin
    #20000000;
    $display("tb_box_non_max_suppression_top: FAIL");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/bnms_pkg.sv
hdl/bnms_iou_unit.sv
hdl/box_non_max_suppression_top.sv
tb/sv/tb_box_non_max_suppression_top.sv
